### hw/rtl/fpn_pkg.sv
// Shared types, constants and the gradient function for the fractal Perlin noise pixel block.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package fpn_pkg;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 25;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_STEP   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OCTAVE_COUNT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PERSISTENCE  = 2'd2;

   localparam logic [24:0] SCALE_RESET  = 25'd1677722;
   localparam logic [3:0]  OCTAVE_RESET = 4'd4;
   localparam logic [15:0] PERS_RESET   = 16'd3072;

   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_LOAD   = 1'b1;

   // operand and product widths of the shared multiplier
   localparam int MUL_A_W = 38;
   localparam int MUL_B_W = 29;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;

   localparam int AMP_W    = 37;
   localparam int TOTAL_W  = 56;
   localparam int MAXSUM_W = 52;
   localparam int DVD_W    = 64;
   localparam int DVS_W    = MAXSUM_W + 1;
   localparam int DIV_STEPS = 9;

   localparam logic [AMP_W-1:0] AMP_ONE = 37'd4096;
   localparam logic [AMP_W-1:0] AMP_CAP = 37'h10_0000_0000;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_P0, ST_P1, ST_P2,
      ST_A, ST_B, ST_C, ST_D, ST_E, ST_F, ST_G, ST_H, ST_I, ST_J, ST_K, ST_L,
      ST_FIN, ST_DIV, ST_DIVW, ST_OUT
   } fpn_state_type;

   // eight gradients: +-u +-2v, with u/v swapped for hash values 4..7
   function automatic logic signed [27:0] fpn_grad(input logic [2:0] h,
                                                    input logic signed [25:0] x,
                                                    input logic signed [25:0] y);
      logic signed [27:0] u;
      logic signed [27:0] v;
      logic signed [27:0] su;
      logic signed [27:0] sv;
      u  = h[2] ? 28'(y) : 28'(x);
      v  = h[2] ? 28'(x) : 28'(y);
      su = h[0] ? -u : u;
      sv = h[1] ? -(v <<< 1) : (v <<< 1);
      return su + sv;
   endfunction

endpackage

### hw/rtl/fpn_perm_ram.sv
// Permutation table memory: one write port, one read port with registered data.
// Uses fpn_pkg for house conventions only.
`timescale 1ns / 1ps

module fpn_perm_ram #(
   parameter int DEPTH = 256,
   parameter int AW    = 8
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);
   import fpn_pkg::*;

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/fpn_divider.sv
// Restoring divider, one quotient bit per cycle, quotient saturated to 255.
// Depends on fpn_pkg for widths.
`timescale 1ns / 1ps

module fpn_divider (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [fpn_pkg::DVD_W-1:0] dividend,
   input  logic [fpn_pkg::DVS_W-1:0] divisor,
   output logic                      done,
   output logic [7:0]                quotient
);
   import fpn_pkg::*;

   logic [DVD_W-1:0]   rem_ff;
   logic [DVS_W+7:0]   dsh_ff;
   logic [8:0]         q_ff;
   logic [3:0]         cnt_ff;
   logic               run_ff;
   logic               done_ff;
   logic               take;
   logic [DVD_W-1:0]   dsh_ext;

   assign dsh_ext = DVD_W'(dsh_ff);
   assign take    = rem_ff >= dsh_ext;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
         end else if (run_ff && cnt_ff == 4'(DIV_STEPS - 1)) begin
            run_ff  <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= dividend;
         dsh_ff <= {divisor, 8'b0};
         q_ff   <= '0;
         cnt_ff <= '0;
      end else if (run_ff) begin
         if (take) begin
            rem_ff <= rem_ff - dsh_ext;
         end
         q_ff   <= {q_ff[7:0], take};
         dsh_ff <= dsh_ff >> 1;
         cnt_ff <= cnt_ff + 4'd1;
      end
   end

   assign done     = done_ff;
   assign quotient = q_ff[8] ? 8'hFF : q_ff[7:0];

endmodule

### hw/rtl/fractal_perlin_noise_pixel_top.sv
// Top level of the fractal Perlin noise pixel block: sequencer, shared multiplier, registers.
// Depends on fpn_pkg, fpn_perm_ram and fpn_divider.
`timescale 1ns / 1ps

// Channel  Handshake            Payload
// req      req_valid/req_stall  operation, pixel_col, pixel_row, table_index, table_value
// rsp      rsp_valid/rsp_stall  gray_level, out_col, out_row
// csr      csr_valid/csr_ready  csr_index, csr_wdata
//
// Load items are taken back to back while idle; a sample item stalls the request channel
// until its result enters the output register. Every octave runs its fade, gradient, lerp
// and amplitude products one after another through the single 38x29 multiplier, and the
// final scaling runs through a bit-serial divider of 9 steps. Reset is synchronous and
// clears control and configuration; the permutation table is not cleared. A stalled result
// sits in the output register while load items are still taken.

module fractal_perlin_noise_pixel_top #(
   parameter int PERM_SIZE   = 256,
   parameter int MAX_OCTAVES = 10
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_operation,
   input  logic [11:0]                    req_pixel_col,
   input  logic [11:0]                    req_pixel_row,
   input  logic [7:0]                     req_table_index,
   input  logic [7:0]                     req_table_value,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [7:0]                     rsp_gray_level,
   output logic [11:0]                    rsp_out_col,
   output logic [11:0]                    rsp_out_row,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [fpn_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [fpn_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import fpn_pkg::*;

   localparam int AW  = (PERM_SIZE > 1) ? $clog2(PERM_SIZE) : 1;
   localparam int OCW = $clog2(MAX_OCTAVES + 1);

   fpn_state_type state_ff, state_in;

   logic [24:0]  scale_ff;
   logic [3:0]   octs_ff;
   logic [15:0]  pers_ff;

   logic [11:0]  col_ff, row_ff;
   logic [31:0]  xs_ff, ys_ff;
   logic [23:0]  t2_ff;
   logic [24:0]  u_ff, v_ff;
   logic [AW-1:0] px0_ff, px1_ff;
   logic [2:0]   h00_ff, h01_ff, h10_ff, h11_ff;
   logic signed [27:0] row0_ff;
   logic signed [TOTAL_W-1:0] total_ff;
   logic [MAXSUM_W-1:0] maxsum_ff;
   logic [AMP_W-1:0] amp_ff;
   logic [OCW-1:0] oct_ff;
   logic [OCW-1:0] oct_lim;
   logic signed [TOTAL_W:0] num_ff;
   logic [7:0]   gray_ff;

   logic         rsp_valid_ff;
   logic [7:0]   rsp_gray_ff;
   logic [11:0]  rsp_col_ff, rsp_row_ff;

   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  prod_ff;

   logic [AW-1:0] mod_lut [256];
   logic [AW-1:0] x0, x1, y0, y1, rd_mod, hash_addr, hash_base, hash_ofs;
   logic [AW:0]   hash_sum;
   logic [AW-1:0] rd_addr;
   logic [7:0]    rd_data;
   logic          wr_en;

   logic [23:0]   tx, ty, t_sel, t2_new;
   logic signed [30:0] q_raw;
   logic [27:0]   q_val;
   logic signed [25:0] txs, tys, txm, tym;
   logic signed [27:0] ga, gb, gc, gd;
   logic signed [28:0] lerp_delta;
   logic signed [28:0] row1_w, noise_w;
   logic [39:0]   amp_next;

   logic          accept;
   logic          div_start, div_done;
   logic [7:0]    div_q;
   logic [DVD_W-1:0] dividend;
   logic          out_free;

   genvar g;
   generate
      for (g = 0; g < 256; g++) begin : gen_mod
         assign mod_lut[g] = AW'(g % PERM_SIZE);
      end
   endgenerate

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign wr_en = accept && (req_operation == OP_LOAD) && (32'(req_table_index) < PERM_SIZE);

   fpn_perm_ram #(.DEPTH(PERM_SIZE), .AW(AW)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AW'(req_table_index)),
      .wr_data (req_table_value),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // lattice indices and hash addressing
   assign x0 = mod_lut[xs_ff[31:24]];
   assign y0 = mod_lut[ys_ff[31:24]];
   assign x1 = (32'(x0) == PERM_SIZE - 1) ? '0 : x0 + AW'(1);
   assign y1 = (32'(y0) == PERM_SIZE - 1) ? '0 : y0 + AW'(1);
   assign rd_mod = mod_lut[rd_data];

   always_comb begin
      hash_base = px0_ff;
      hash_ofs  = y0;
      unique case (state_ff)
         ST_C:    begin hash_base = px0_ff; hash_ofs = y0; end
         ST_D:    begin hash_base = px0_ff; hash_ofs = y1; end
         ST_E:    begin hash_base = px1_ff; hash_ofs = y0; end
         ST_F:    begin hash_base = px1_ff; hash_ofs = y1; end
         default: begin hash_base = px0_ff; hash_ofs = y0; end
      endcase
   end

   assign hash_sum  = {1'b0, hash_base} + {1'b0, hash_ofs};
   assign hash_addr = (32'(hash_sum) >= PERM_SIZE) ? AW'(32'(hash_sum) - PERM_SIZE)
                                                   : hash_sum[AW-1:0];

   always_comb begin
      unique case (state_ff)
         ST_A:    rd_addr = x0;
         ST_B:    rd_addr = x1;
         ST_C, ST_D, ST_E, ST_F: rd_addr = hash_addr;
         default: rd_addr = x0;
      endcase
   end

   // fade polynomial pieces
   assign tx     = xs_ff[23:0];
   assign ty     = ys_ff[23:0];
   assign t_sel  = (state_ff == ST_C || state_ff == ST_B) ? tx : ty;
   assign t2_new = prod_ff[47:24];
   assign q_raw  = 31'sd167772160 + $signed({7'b0, t2_ff}) * 31'sd6
                   - $signed({7'b0, t_sel}) * 31'sd15;
   assign q_val  = (q_raw < 0) ? '0 : q_raw[27:0];

   // gradients at the four corners
   assign txs = $signed({2'b00, tx});
   assign tys = $signed({2'b00, ty});
   assign txm = txs - 26'sd16777216;
   assign tym = tys - 26'sd16777216;
   assign ga  = fpn_grad(h00_ff, txs, tys);
   assign gb  = fpn_grad(h10_ff, txm, tys);
   assign gc  = fpn_grad(h01_ff, txs, tym);
   assign gd  = fpn_grad(h11_ff, txm, tym);

   assign lerp_delta = $signed(prod_ff[52:24]);
   assign row1_w     = 29'(gc) + lerp_delta;
   assign noise_w    = 29'(row0_ff) + lerp_delta;
   assign amp_next   = prod_ff[51:12];

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_P0:   begin mul_a = MUL_A_W'(scale_ff); mul_b = MUL_B_W'(col_ff); end
         ST_P1:   begin mul_a = MUL_A_W'(scale_ff); mul_b = MUL_B_W'(row_ff); end
         ST_A:    begin mul_a = MUL_A_W'(tx); mul_b = MUL_B_W'(tx); end
         ST_B:    begin mul_a = MUL_A_W'(t2_new); mul_b = MUL_B_W'(tx); end
         ST_C:    begin mul_a = MUL_A_W'(t2_new); mul_b = MUL_B_W'(q_val); end
         ST_D:    begin mul_a = MUL_A_W'(ty); mul_b = MUL_B_W'(ty); end
         ST_E:    begin mul_a = MUL_A_W'(t2_new); mul_b = MUL_B_W'(ty); end
         ST_F:    begin mul_a = MUL_A_W'(t2_new); mul_b = MUL_B_W'(q_val); end
         ST_G:    begin mul_a = MUL_A_W'(u_ff); mul_b = 29'(gb) - 29'(ga); end
         ST_H:    begin mul_a = MUL_A_W'(u_ff); mul_b = 29'(gd) - 29'(gc); end
         ST_I:    begin mul_a = MUL_A_W'(v_ff); mul_b = row1_w - 29'(row0_ff); end
         ST_J:    begin mul_a = MUL_A_W'(amp_ff); mul_b = noise_w; end
         ST_K:    begin mul_a = MUL_A_W'(amp_ff); mul_b = MUL_B_W'(pers_ff); end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   // clamp octave count to 1..MAX_OCTAVES
   always_comb begin
      priority if (octs_ff == 4'd0) begin
         oct_lim = OCW'(1);
      end else if (32'(octs_ff) > MAX_OCTAVES) begin
         oct_lim = OCW'(MAX_OCTAVES);
      end else begin
         oct_lim = OCW'(octs_ff);
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= SCALE_RESET;
         octs_ff  <= OCTAVE_RESET;
         pers_ff  <= PERS_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SCALE_STEP:   scale_ff <= csr_wdata[24:0];
            CSR_OCTAVE_COUNT: octs_ff  <= csr_wdata[3:0];
            CSR_PERSISTENCE:  pers_ff  <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      div_start = 1'b0;
      unique case (state_ff)
         ST_IDLE: if (accept && req_operation == OP_SAMPLE) state_in = ST_P0;
         ST_P0:   state_in = ST_P1;
         ST_P1:   state_in = ST_P2;
         ST_P2:   state_in = ST_A;
         ST_A:    state_in = ST_B;
         ST_B:    state_in = ST_C;
         ST_C:    state_in = ST_D;
         ST_D:    state_in = ST_E;
         ST_E:    state_in = ST_F;
         ST_F:    state_in = ST_G;
         ST_G:    state_in = ST_H;
         ST_H:    state_in = ST_I;
         ST_I:    state_in = ST_J;
         ST_J:    state_in = ST_K;
         ST_K:    state_in = ST_L;
         ST_L:    state_in = (oct_ff + OCW'(1) == oct_lim) ? ST_FIN : ST_A;
         ST_FIN:  state_in = ST_DIV;
         ST_DIV: begin
            if (num_ff <= 0) begin
               state_in = ST_OUT;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIVW;
            end
         end
         ST_DIVW: if (div_done) state_in = ST_OUT;
         ST_OUT:  if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath captures
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               col_ff    <= req_pixel_col;
               row_ff    <= req_pixel_row;
               total_ff  <= '0;
               maxsum_ff <= '0;
               amp_ff    <= AMP_ONE;
               oct_ff    <= '0;
            end
         end
         ST_P1: xs_ff <= prod_ff[31:0];
         ST_P2: ys_ff <= prod_ff[31:0];
         ST_B: begin
            px0_ff <= rd_mod;
            t2_ff  <= t2_new;
         end
         ST_C: px1_ff <= rd_mod;
         ST_D: begin
            u_ff   <= prod_ff[48:24];
            h00_ff <= rd_data[2:0];
         end
         ST_E: begin
            h01_ff <= rd_data[2:0];
            t2_ff  <= t2_new;
         end
         ST_F: h10_ff <= rd_data[2:0];
         ST_G: begin
            h11_ff <= rd_data[2:0];
            v_ff   <= prod_ff[48:24];
         end
         ST_H: row0_ff <= 28'(29'(ga) + lerp_delta);
         ST_K: begin
            total_ff  <= total_ff + TOTAL_W'($signed(prod_ff[PROD_W-1:12]));
            maxsum_ff <= maxsum_ff + MAXSUM_W'({amp_ff, 12'b0});
         end
         ST_L: begin
            amp_ff <= (amp_next > 40'(AMP_CAP)) ? AMP_CAP : amp_next[AMP_W-1:0];
            xs_ff  <= xs_ff << 1;
            ys_ff  <= ys_ff << 1;
            oct_ff <= oct_ff + OCW'(1);
         end
         ST_FIN: num_ff <= (TOTAL_W + 1)'(total_ff) + $signed({1'b0, 4'b0, maxsum_ff});
         ST_DIV: gray_ff <= '0;
         ST_DIVW: if (div_done) gray_ff <= div_q;
         default: ;
      endcase
   end

   // num * 255 as (num << 8) - num; num is positive whenever the divider runs
   assign dividend = (DVD_W'(num_ff) << 8) - DVD_W'(num_ff);

   fpn_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  ({maxsum_ff, 1'b0}),
      .done     (div_done),
      .quotient (div_q)
   );

   // output register: hold until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_OUT && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_OUT && out_free) begin
         rsp_gray_ff <= gray_ff;
         rsp_col_ff  <= col_ff;
         rsp_row_ff  <= row_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_gray_level = rsp_gray_ff;
   assign rsp_out_col    = rsp_col_ff;
   assign rsp_out_row    = rsp_row_ff;

endmodule

### test/fractal_perlin_noise_pixel_top_test.sv
// Self-checking testbench for fractal_perlin_noise_pixel_top: loads the permutation table,
// samples pixels under several register settings and checks each gray level against a predictor.
// Depends on fpn_pkg and the RTL of fractal_perlin_noise_pixel_top.
`timescale 1ns / 1ps

typedef struct {
   logic [7:0]  gray;
   logic [11:0] col;
   logic [11:0] row;
} pixel_result_type;

class noise_scoreboard;
   localparam longint Q24_ONE = 64'sd1 << 24;
   localparam longint AMP_CAP = 64'sd1 << 36;

   logic [7:0]  perm [256];
   logic [24:0] scale_step;
   logic [3:0]  octaves;
   logic [15:0] persistence;
   pixel_result_type pending_pixels [$];
   int errors;

   function new();
      scale_step = fpn_pkg::SCALE_RESET;
      octaves = fpn_pkg::OCTAVE_RESET;
      persistence = fpn_pkg::PERS_RESET;
      errors = 0;
      foreach (perm[i]) perm[i] = 8'd0;
   endfunction

   function void write_reg(logic [1:0] idx, logic [24:0] data);
      case (idx)
         fpn_pkg::CSR_SCALE_STEP:   scale_step = data;
         fpn_pkg::CSR_OCTAVE_COUNT: octaves = data[3:0];
         fpn_pkg::CSR_PERSISTENCE:  persistence = data[15:0];
         default: ;
      endcase
   endfunction

   function longint fade(longint t);
      longint t2, t3, q;
      t2 = (t * t) >>> 24;
      t3 = (t2 * t) >>> 24;
      q = 10 * Q24_ONE + 6 * t2 - 15 * t;
      if (q < 0) q = 0;
      return (t3 * q) >>> 24;
   endfunction

   function longint blend(longint t, longint a, longint b);
      return a + (((b - a) * t) >>> 24);
   endfunction

   function longint grad(logic [2:0] h, longint x, longint y);
      longint u, v;
      u = h[2] ? y : x;
      v = h[2] ? x : y;
      if (h[0]) u = -u;
      v = h[1] ? -2 * v : 2 * v;
      return u + v;
   endfunction

   function logic [2:0] corner_hash(logic [7:0] xi, logic [7:0] yi);
      logic [7:0] first;
      first = perm[xi] + yi;
      return perm[first][2:0];
   endfunction

   function longint lattice_noise(logic [31:0] xc, logic [31:0] yc);
      logic [7:0] x0, y0;
      longint tx, ty, u, v, a, b, c, d;
      x0 = xc[31:24];
      y0 = yc[31:24];
      tx = longint'(xc[23:0]);
      ty = longint'(yc[23:0]);
      u = fade(tx);
      v = fade(ty);
      a = grad(corner_hash(x0, y0), tx, ty);
      b = grad(corner_hash(x0 + 8'd1, y0), tx - Q24_ONE, ty);
      c = grad(corner_hash(x0, y0 + 8'd1), tx, ty - Q24_ONE);
      d = grad(corner_hash(x0 + 8'd1, y0 + 8'd1), tx - Q24_ONE, ty - Q24_ONE);
      return blend(v, blend(u, a, b), blend(u, c, d));
   endfunction

   function logic [7:0] gray_of(logic [11:0] col, logic [11:0] row);
      logic [63:0] xp, yp;
      logic [31:0] xs, ys;
      longint amp, total, maxsum, num;
      logic [63:0] g;
      int n_oct;
      xp = 64'(col) * 64'(scale_step);
      yp = 64'(row) * 64'(scale_step);
      n_oct = (octaves < 1) ? 1 : (octaves > 10) ? 10 : octaves;
      amp = 4096;
      total = 0;
      maxsum = 0;
      for (int i = 0; i < n_oct; i++) begin
         xs = xp[31:0] << i;
         ys = yp[31:0] << i;
         total += (lattice_noise(xs, ys) * amp) >>> 12;
         maxsum += amp << 12;
         amp = (amp * longint'(persistence)) >>> 12;
         if (amp > AMP_CAP) amp = AMP_CAP;
      end
      num = total + maxsum;
      if (num <= 0) return 8'd0;
      g = (64'(num) * 64'd255) / (64'(maxsum) * 64'd2);
      return (g > 255) ? 8'd255 : g[7:0];
   endfunction

   // note one accepted input item: a load updates the table, a sample queues its pixel
   function void note_item(logic op, logic [11:0] col, logic [11:0] row,
                           logic [7:0] idx, logic [7:0] val);
      pixel_result_type r;
      if (op == fpn_pkg::OP_LOAD) begin
         perm[idx] = val;
      end else begin
         r.gray = gray_of(col, row);
         r.col = col;
         r.row = row;
         pending_pixels.push_back(r);
      end
   endfunction

   function void check_pixel(logic [7:0] gray, logic [11:0] col, logic [11:0] row);
      pixel_result_type e;
      if (pending_pixels.size() == 0) begin
         $display("%0t: unexpected pixel gray=%0d col=%0d row=%0d", $time, gray, col, row);
         errors++;
         return;
      end
      e = pending_pixels.pop_front();
      if (gray !== e.gray || col !== e.col || row !== e.row) begin
         $display("%0t: expected gray=%0d col=%0d row=%0d, got gray=%0d col=%0d row=%0d",
                  $time, e.gray, e.col, e.row, gray, col, row);
         errors++;
      end
   endfunction
endclass

module fractal_perlin_noise_pixel_top_test;
   import fpn_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int SETTLE_CYCLES = 300;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_operation = OP_SAMPLE;
   logic [11:0] req_pixel_col = '0;
   logic [11:0] req_pixel_row = '0;
   logic [7:0]  req_table_index = '0;
   logic [7:0]  req_table_value = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_gray_level;
   logic [11:0] rsp_out_col;
   logic [11:0] rsp_out_row;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   noise_scoreboard pixels = new();
   int idle_pct = 0;
   int stall_pct = 0;
   int hold_cycles = 0;
   int quiet_cycles = 0;

   fractal_perlin_noise_pixel_top u_dut (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         pixels.note_item(req_operation, req_pixel_col, req_pixel_row,
                          req_table_index, req_table_value);
      if (!reset && rsp_valid && !rsp_stall)
         pixels.check_pixel(rsp_gray_level, rsp_out_col, rsp_out_row);
   end

   // receiver: random stall, or a long hold when one is requested
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("fractal_perlin_noise_pixel_top: mismatch");
         $finish;
      end
   end

   task automatic send_item(logic op, logic [11:0] col, logic [11:0] row,
                            logic [7:0] idx, logic [7:0] val);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_pixel_col <= col;
      req_pixel_row <= row;
      req_table_index <= idx;
      req_table_value <= val;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_pixel(logic [11:0] col, logic [11:0] row);
      send_item(OP_SAMPLE, col, row, 8'($urandom), 8'($urandom));
   endtask

   task automatic send_load(logic [7:0] idx, logic [7:0] val);
      send_item(OP_LOAD, 12'($urandom), 12'($urandom), idx, val);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      pixels.write_reg(idx, data);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pixels.pending_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [11:0] pick_coord();
      case ($urandom_range(9))
         0: return 12'd0;
         1: return 12'd4095;
         default: return 12'($urandom);
      endcase
   endfunction

   initial begin
      logic [7:0] shuffle [256];
      logic [7:0] tmp;
      int j;
      logic [24:0] scales [8];
      logic [3:0]  octs [8];
      logic [15:0] pers [8];

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // full table first so that no sample reads an unwritten entry
      foreach (shuffle[i]) shuffle[i] = 8'(i);
      for (int i = 255; i > 0; i--) begin
         j = $urandom_range(i);
         tmp = shuffle[i];
         shuffle[i] = shuffle[j];
         shuffle[j] = tmp;
      end
      foreach (shuffle[i]) send_load(8'(i), shuffle[i]);

      send_pixel(12'd0, 12'd0);
      send_pixel(12'd4095, 12'd4095);
      send_pixel(12'd4095, 12'd0);
      send_pixel(12'd0, 12'd4095);
      send_load(8'd255, 8'd255);
      send_load(8'd0, 8'd0);
      send_pixel(12'd10, 12'd9);
      send_pixel(12'd2730, 12'd1365);
      send_load(8'd255, shuffle[255]);
      send_load(8'd0, shuffle[0]);
      send_pixel(12'd1, 12'd1);
      drain();

      scales = '{25'd0, 25'd16777216, 25'h1FFFFFF, 25'd1, 25'd1677722,
                 25'd16777216, 25'd0, 25'd1677722};
      octs   = '{4'd1, 4'd10, 4'd0, 4'd15, 4'd4, 4'd2, 4'd7, 4'd3};
      pers   = '{16'd0, 16'd65535, 16'd4096, 16'd3072, 16'd65535, 16'd0, 16'd2048, 16'd8192};

      for (int ph = 0; ph < 8; ph++) begin
         // scale random in phase 4 to cover every data bit
         write_csr(CSR_SCALE_STEP, (ph == 4) ? 25'($urandom) : scales[ph]);
         write_csr(CSR_OCTAVE_COUNT, {21'($urandom), octs[ph]});
         write_csr(CSR_PERSISTENCE, (ph == 6) ? {9'($urandom), 16'($urandom)}
                                              : {9'($urandom), pers[ph]});
         write_csr(CSR_UNMAPPED, 25'($urandom));
         case (ph % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 73; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 73; end
            default: begin idle_pct = 15; stall_pct = 15; end
         endcase
         if (ph == 3) hold_cycles = 600;
         for (int k = 0; k < 130; k++) begin
            if ($urandom_range(99) < 15)
               send_load(8'($urandom), 8'($urandom));
            else
               send_pixel(pick_coord(), pick_coord());
            if (k == 80 && (ph % 4) == 0) begin
               idle_pct = 0;
               stall_pct = 0;
            end
         end
         drain();
      end

      if (pixels.errors == 0 && pixels.pending_pixels.size() == 0) begin
         $display("fractal_perlin_noise_pixel_top: match");
      end else begin
         $display("fractal_perlin_noise_pixel_top: mismatch");
      end
      $finish;
   end
endmodule

### fractal_perlin_noise_pixel_top.f
hw/rtl/fpn_pkg.sv
hw/rtl/fpn_perm_ram.sv
hw/rtl/fpn_divider.sv
hw/rtl/fractal_perlin_noise_pixel_top.sv
test/fractal_perlin_noise_pixel_top_test.sv
